[rtl/i2c_register_access_sequencer_macros.svh]
// Assertion macros shared by the register access sequencer RTL.
// Every macro expects i_clk and i_rst_n to be in scope where it is used.
`ifndef I2C_REGISTER_ACCESS_SEQUENCER_MACROS_SVH
`define I2C_REGISTER_ACCESS_SEQUENCER_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define I2C_RAS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// A condition at one edge implies a consequence at the next edge.
`define I2C_RAS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/i2c_ras_pkg.sv]
// Package for the I2C register access sequencer: item types, codes and
// status checks. No dependencies.
`default_nettype none

package i2c_ras_pkg;

    // Input request types.
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_DONE  = 2'd2;
    localparam logic [1:0] REQ_TICK  = 2'd3;

    // Commands to the byte engine.
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_SEND  = 2'd1;
    localparam logic [1:0] CMD_RECV  = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    // Transaction result codes.
    localparam logic [1:0] RES_OK      = 2'd0;
    localparam logic [1:0] RES_TIMEOUT = 2'd1;
    localparam logic [1:0] RES_ERROR   = 2'd2;

    // Output item kinds.
    localparam logic KIND_CMD    = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // Byte engine status codes.
    localparam logic [7:0] ST_START     = 8'h08;
    localparam logic [7:0] ST_RSTART    = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
    localparam logic [7:0] ST_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
    localparam logic [7:0] ST_RECV_NACK = 8'h58;

    localparam logic [15:0] TIMEOUT_RESET = 16'd10000;

    typedef struct packed {
        logic [1:0] req_type;
        logic [6:0] device_address;
        logic [7:0] register_address;
        logic [7:0] write_value;
        logic [7:0] bus_status;
        logic [7:0] bus_read_byte;
    } t_in_item;

    typedef struct packed {
        logic       out_kind;
        logic [1:0] bus_command;
        logic [7:0] send_byte;
        logic [1:0] result_code;
        logic [7:0] read_value;
        logic       last_of_run;
    } t_out_item;

    // One queued action: either a single command, or the end of a
    // transaction (a stop command followed by a finish item).
    typedef struct packed {
        logic       is_end;
        logic [1:0] bus_command;
        logic [7:0] send_byte;
        logic [1:0] result_code;
        logic [7:0] read_value;
    } t_action;

    function automatic logic status_start_ok(input logic [7:0] s);
        return (s == ST_START) || (s == ST_RSTART);
    endfunction

    function automatic logic status_send_ok(input logic [7:0] s);
        return (s == ST_SLAW_ACK) || (s == ST_DATA_ACK);
    endfunction

    function automatic logic status_slar_ok(input logic [7:0] s);
        return (s == ST_SLAW_ACK) || (s == ST_DATA_ACK) || (s == ST_SLAR_ACK);
    endfunction

endpackage

`default_nettype wire

[rtl/i2c_register_access_sequencer.sv]
// I2C register access sequencer, top level: front part, action queue and
// back part. Uses i2c_ras_pkg, i2c_ras_front, i2c_ras_queue and i2c_ras_back.
//
// Usage: the input channel (i_valid, o_stall, i_data) carries write-register
// and read-register requests, bus step completions from the byte engine, and
// ticks. The output channel (o_valid, i_stall, o_data) carries commands for the
// byte engine and transaction finish items. An item moves when valid is high
// and stall is low. The timeout limit is written through i_cfg_we/i_cfg_wdata
// while the block is idle; it resets to 10000 ticks per bus step.
// Each input item is handled by the front part, which keeps the transaction
// phase and the wait counter, and any result goes into a queue of QUEUE_DEPTH
// actions. A result item is written into the queue when its input item is
// accepted and moves from the queue head into the output register once that
// register is free. One input item per cycle is accepted while the queue is
// not full; an item ending a transaction gives two results (stop, then finish),
// so the output port sets the sustained rate when many items end transactions.
// When the receiver stalls, the output register holds its item, the queue
// fills, and o_stall rises once the queue is full. Synchronous reset returns
// the block to idle with an empty queue and no valid output.
`default_nettype none

module i2c_register_access_sequencer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire i2c_ras_pkg::t_in_item  i_data,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output i2c_ras_pkg::t_out_item      o_data,
    input  wire logic                   i_cfg_we,
    input  wire logic [15:0]            i_cfg_wdata
);
    import i2c_ras_pkg::*;

    logic    push;
    t_action push_action;
    logic    pop;
    t_action head;
    logic    q_empty;
    logic    q_full;

    assign o_stall = q_full;

    i2c_ras_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_data       (i_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_queue_full (q_full),
        .o_push       (push),
        .o_action     (push_action)
    );

    i2c_ras_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_action),
        .i_pop       (pop),
        .o_head      (head),
        .o_empty     (q_empty),
        .o_full      (q_full)
    );

    i2c_ras_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (q_empty),
        .o_pop   (pop),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule

`default_nettype wire

[rtl/i2c_ras_front.sv]
// Front part of the sequencer: accepts input items, runs the transaction
// phase machine and the timeout counter, and pushes actions. Uses i2c_ras_pkg.
`default_nettype none

module i2c_ras_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire i2c_ras_pkg::t_in_item i_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [15:0]           i_cfg_wdata,
    input  wire logic                  i_queue_full,
    output logic                       o_push,
    output i2c_ras_pkg::t_action       o_action
);
    import i2c_ras_pkg::*;

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_START  = 4'd1;
    localparam logic [3:0] PH_SLAW   = 4'd2;
    localparam logic [3:0] PH_REG    = 4'd3;
    localparam logic [3:0] PH_DATA   = 4'd4;
    localparam logic [3:0] PH_RSTART = 4'd5;
    localparam logic [3:0] PH_SLAR   = 4'd6;
    localparam logic [3:0] PH_RECV   = 4'd7;

    logic [3:0]  r_phase,  n_phase;
    logic        r_is_read, n_is_read;
    logic [6:0]  r_device, n_device;
    logic [7:0]  r_register, n_register;
    logic [7:0]  r_value,  n_value;
    logic [15:0] r_wait,   n_wait;
    logic [15:0] r_limit;

    logic        accept;
    logic        do_issue;
    logic [3:0]  issue_phase;
    logic [1:0]  issue_cmd;
    logic [7:0]  issue_byte;
    logic        do_end;
    logic [1:0]  end_code;
    logic [7:0]  end_value;

    assign accept = i_valid && !i_queue_full;

    always_comb begin
        n_phase     = r_phase;
        n_is_read   = r_is_read;
        n_device    = r_device;
        n_register  = r_register;
        n_value     = r_value;
        n_wait      = r_wait;
        do_issue    = 1'b0;
        issue_phase = PH_IDLE;
        issue_cmd   = CMD_START;
        issue_byte  = 8'd0;
        do_end      = 1'b0;
        end_code    = RES_OK;
        end_value   = 8'd0;

        if (accept) begin
            if (i_data.req_type == REQ_WRITE || i_data.req_type == REQ_READ) begin
                if (r_phase == PH_IDLE) begin
                    n_is_read   = (i_data.req_type == REQ_READ);
                    n_device    = i_data.device_address;
                    n_register  = i_data.register_address;
                    n_value     = i_data.write_value;
                    do_issue    = 1'b1;
                    issue_phase = PH_START;
                    issue_cmd   = CMD_START;
                end
            end else if (r_phase != PH_IDLE) begin
                if (i_data.req_type == REQ_TICK) begin
                    if (r_wait >= r_limit) begin
                        do_end   = 1'b1;
                        end_code = RES_TIMEOUT;
                    end else begin
                        n_wait = r_wait + 16'd1;
                    end
                end else begin
                    // A bus step has completed; check its status.
                    case (r_phase)
                        PH_START: begin
                            if (!status_start_ok(i_data.bus_status)) begin
                                do_end   = 1'b1;
                                end_code = RES_ERROR;
                            end else begin
                                do_issue    = 1'b1;
                                issue_phase = PH_SLAW;
                                issue_cmd   = CMD_SEND;
                                issue_byte  = {r_device, 1'b0};
                            end
                        end
                        PH_SLAW: begin
                            if (!status_send_ok(i_data.bus_status)) begin
                                do_end   = 1'b1;
                                end_code = RES_ERROR;
                            end else begin
                                do_issue    = 1'b1;
                                issue_phase = PH_REG;
                                issue_cmd   = CMD_SEND;
                                issue_byte  = r_register;
                            end
                        end
                        PH_REG: begin
                            if (!status_send_ok(i_data.bus_status)) begin
                                do_end   = 1'b1;
                                end_code = RES_ERROR;
                            end else if (r_is_read) begin
                                do_issue    = 1'b1;
                                issue_phase = PH_RSTART;
                                issue_cmd   = CMD_START;
                            end else begin
                                do_issue    = 1'b1;
                                issue_phase = PH_DATA;
                                issue_cmd   = CMD_SEND;
                                issue_byte  = r_value;
                            end
                        end
                        PH_DATA: begin
                            do_end   = 1'b1;
                            end_code = status_send_ok(i_data.bus_status) ? RES_OK : RES_ERROR;
                        end
                        PH_RSTART: begin
                            if (!status_start_ok(i_data.bus_status)) begin
                                do_end   = 1'b1;
                                end_code = RES_ERROR;
                            end else begin
                                do_issue    = 1'b1;
                                issue_phase = PH_SLAR;
                                issue_cmd   = CMD_SEND;
                                issue_byte  = {r_device, 1'b1};
                            end
                        end
                        PH_SLAR: begin
                            if (!status_slar_ok(i_data.bus_status)) begin
                                do_end   = 1'b1;
                                end_code = RES_ERROR;
                            end else begin
                                do_issue    = 1'b1;
                                issue_phase = PH_RECV;
                                issue_cmd   = CMD_RECV;
                            end
                        end
                        PH_RECV: begin
                            do_end = 1'b1;
                            if (i_data.bus_status == ST_RECV_NACK) begin
                                end_code  = RES_OK;
                                end_value = i_data.bus_read_byte;
                            end else begin
                                end_code = RES_ERROR;
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                            n_wait  = 16'd0;
                        end
                    endcase
                end
            end
        end

        if (do_issue) begin
            n_phase = issue_phase;
            n_wait  = 16'd0;
        end
        if (do_end) begin
            n_phase = PH_IDLE;
            n_wait  = 16'd0;
        end
    end

    always_comb begin
        o_push               = do_issue || do_end;
        o_action.is_end      = do_end;
        o_action.bus_command = do_end ? CMD_STOP : issue_cmd;
        o_action.send_byte   = do_end ? 8'd0 : issue_byte;
        o_action.result_code = end_code;
        o_action.read_value  = end_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_is_read  <= 1'b0;
            r_device   <= 7'd0;
            r_register <= 8'd0;
            r_value    <= 8'd0;
            r_wait     <= 16'd0;
            r_limit    <= TIMEOUT_RESET;
        end else begin
            r_phase    <= n_phase;
            r_is_read  <= n_is_read;
            r_device   <= n_device;
            r_register <= n_register;
            r_value    <= n_value;
            r_wait     <= n_wait;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/i2c_ras_queue.sv]
// Short action queue between the front and back parts of the sequencer.
// Uses i2c_ras_pkg and the assertion macros header.
`default_nettype none
`include "i2c_register_access_sequencer_macros.svh"

module i2c_ras_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire i2c_ras_pkg::t_action i_push_data,
    input  wire logic                 i_pop,
    output i2c_ras_pkg::t_action      o_head,
    output logic                      o_empty,
    output logic                      o_full
);
    import i2c_ras_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_action       r_slots [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_head  = r_slots[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == FULL_CNT);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `I2C_RAS_ASSERT(a_q_no_overflow, !(i_push && o_full), "push into a full queue")
    `I2C_RAS_ASSERT(a_q_no_underflow, !(i_pop && o_empty), "pop from an empty queue")
    `I2C_RAS_ASSERT_NEXT(a_q_push_fills, i_push && !i_pop, !o_empty, "pushed item was lost")

endmodule

`default_nettype wire

[rtl/i2c_ras_back.sv]
// Back part of the sequencer: expands queued actions into result items and
// holds them in the output register. Uses i2c_ras_pkg and the macros header.
`default_nettype none
`include "i2c_register_access_sequencer_macros.svh"

module i2c_ras_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire i2c_ras_pkg::t_action i_head,
    input  wire logic                 i_empty,
    output logic                      o_pop,
    input  wire logic                 i_stall,
    output logic                      o_valid,
    output i2c_ras_pkg::t_out_item    o_data
);
    import i2c_ras_pkg::*;

    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;
    // Set once the stop of an ending action is loaded into the output register; its finish follows.
    logic      r_half, n_half;
    logic      load;
    logic      stop_load;
    logic      out_finish;

    assign load       = !r_out_valid || !i_stall;
    assign stop_load  = load && !i_empty && i_head.is_end && !r_half;
    assign out_finish = r_out_valid && (r_out.out_kind == KIND_FINISH);

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_half      = r_half;
        o_pop       = 1'b0;
        if (load) begin
            n_out_valid = !i_empty;
            if (!i_empty) begin
                if (!i_head.is_end) begin
                    n_out.out_kind    = KIND_CMD;
                    n_out.bus_command = i_head.bus_command;
                    n_out.send_byte   = i_head.send_byte;
                    n_out.result_code = RES_OK;
                    n_out.read_value  = 8'd0;
                    n_out.last_of_run = 1'b1;
                    o_pop             = 1'b1;
                end else if (!r_half) begin
                    n_out.out_kind    = KIND_CMD;
                    n_out.bus_command = CMD_STOP;
                    n_out.send_byte   = 8'd0;
                    n_out.result_code = RES_OK;
                    n_out.read_value  = 8'd0;
                    n_out.last_of_run = 1'b0;
                    n_half            = 1'b1;
                end else begin
                    n_out.out_kind    = KIND_FINISH;
                    n_out.bus_command = CMD_START;
                    n_out.send_byte   = 8'd0;
                    n_out.result_code = i_head.result_code;
                    n_out.read_value  = i_head.read_value;
                    n_out.last_of_run = 1'b1;
                    n_half            = 1'b0;
                    o_pop             = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_half      <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_half      <= n_half;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `I2C_RAS_ASSERT(a_b_half_has_head, !r_half || !i_empty, "pending finish without action")
    `I2C_RAS_ASSERT_NEXT(a_b_stop_then_finish, stop_load, r_half, "stop not followed by finish")
    `I2C_RAS_ASSERT(a_b_finish_is_last, !out_finish || r_out.last_of_run, "finish not marked last")

endmodule

`default_nettype wire
